// File: sv/dtem_pkg.sv
// Package for the debounced temperature excursion monitor.
// Holds the word, configuration and state types and the fixed constants.
// No dependencies.
package dtem_pkg;

    localparam int TEMP_W = 16;
    localparam int HUM_W  = 14;
    localparam int CNT_W  = 32;
    localparam int RUN_W  = 16;
    localparam int CFG_W  = 16;

    localparam logic [RUN_W-1:0]         RUN_MAX         = '1;
    localparam logic signed [TEMP_W-1:0] SAMPLE_FLOOR_CC = -16'sd27215;
    localparam logic signed [TEMP_W-1:0] MIN_INIT_CC     = 16'sd32767;
    localparam logic signed [TEMP_W-1:0] MAX_INIT_CC     = -16'sd32768;

    localparam logic                     RST_SOURCE_IS_PROBE = 1'b1;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_LOW_CC     = 16'sd200;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_HIGH_CC    = 16'sd800;
    localparam logic [15:0]              RST_DEBOUNCE_COUNT  = 16'd3;
    localparam logic [15:0]              RST_SAMPLE_PERIOD_S = 16'd300;
    localparam logic                     RST_HUM_CHECK_EN    = 1'b0;
    localparam logic [HUM_W-1:0]         RST_HUM_LOW_CPCT    = 14'd1000;
    localparam logic [HUM_W-1:0]         RST_HUM_HIGH_CPCT   = 14'd6000;

    typedef enum logic [2:0] {
        REG_SOURCE_IS_PROBE = 3'd0,
        REG_TEMP_LOW_CC     = 3'd1,
        REG_TEMP_HIGH_CC    = 3'd2,
        REG_DEBOUNCE_COUNT  = 3'd3,
        REG_SAMPLE_PERIOD_S = 3'd4,
        REG_HUM_CHECK_EN    = 3'd5,
        REG_HUM_LOW_CPCT    = 3'd6,
        REG_HUM_HIGH_CPCT   = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic                     probe_valid;
        logic signed [TEMP_W-1:0] probe_temp;
        logic                     ambient_valid;
        logic signed [TEMP_W-1:0] ambient_cc;
        logic                     hum_valid;
        logic [HUM_W-1:0]         humidity_raw;
    } in_word_t;

    typedef struct packed {
        logic                     exc_low;
        logic                     exc_high;
        logic                     exc_hum;
        logic                     alarm_flag;
        logic                     alarm_rise;
        logic [CNT_W-1:0]         event_total;
        logic [CNT_W-1:0]         seconds_low;
        logic [CNT_W-1:0]         seconds_high;
        logic signed [TEMP_W-1:0] lowest_cc;
        logic signed [TEMP_W-1:0] highest_cc;
        logic [CNT_W-1:0]         sample_total;
    } out_word_t;

    typedef struct packed {
        logic                     source_is_probe;
        logic signed [TEMP_W-1:0] temp_low_cc;
        logic signed [TEMP_W-1:0] temp_high_cc;
        logic [15:0]              debounce_count;
        logic [15:0]              sample_period_s;
        logic                     hum_check_enable;
        logic [HUM_W-1:0]         hum_low_cpct;
        logic [HUM_W-1:0]         hum_high_cpct;
    } cfg_t;

    typedef struct packed {
        logic                     alarm_latched;
        logic [RUN_W-1:0]         run_length;
        logic [CNT_W-1:0]         event_count;
        logic [CNT_W-1:0]         low_seconds;
        logic [CNT_W-1:0]         high_seconds;
        logic signed [TEMP_W-1:0] min_seen;
        logic signed [TEMP_W-1:0] max_seen;
        logic [CNT_W-1:0]         sample_count;
    } state_t;

endpackage

// File: sv/dtem_cfg_regs.sv
// Configuration register file of the excursion monitor.
// Uses dtem_pkg for the register index codes, reset values and cfg_t.
module dtem_cfg_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [2:0]                cfg_addr,
    input  logic [dtem_pkg::CFG_W-1:0] cfg_wdata,
    output dtem_pkg::cfg_t            cfg
);

    dtem_pkg::cfg_t     cfg_reg;
    dtem_pkg::cfg_index_t idx;

    assign idx = dtem_pkg::cfg_index_t'(cfg_addr);
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.source_is_probe  <= dtem_pkg::RST_SOURCE_IS_PROBE;
            cfg_reg.temp_low_cc      <= dtem_pkg::RST_TEMP_LOW_CC;
            cfg_reg.temp_high_cc     <= dtem_pkg::RST_TEMP_HIGH_CC;
            cfg_reg.debounce_count   <= dtem_pkg::RST_DEBOUNCE_COUNT;
            cfg_reg.sample_period_s  <= dtem_pkg::RST_SAMPLE_PERIOD_S;
            cfg_reg.hum_check_enable <= dtem_pkg::RST_HUM_CHECK_EN;
            cfg_reg.hum_low_cpct     <= dtem_pkg::RST_HUM_LOW_CPCT;
            cfg_reg.hum_high_cpct    <= dtem_pkg::RST_HUM_HIGH_CPCT;
        end else if (cfg_wr_en) begin
            case (idx)
                dtem_pkg::REG_SOURCE_IS_PROBE: cfg_reg.source_is_probe  <= cfg_wdata[0];
                dtem_pkg::REG_TEMP_LOW_CC:     cfg_reg.temp_low_cc      <= cfg_wdata;
                dtem_pkg::REG_TEMP_HIGH_CC:    cfg_reg.temp_high_cc     <= cfg_wdata;
                dtem_pkg::REG_DEBOUNCE_COUNT:  cfg_reg.debounce_count   <= cfg_wdata;
                dtem_pkg::REG_SAMPLE_PERIOD_S: cfg_reg.sample_period_s  <= cfg_wdata;
                dtem_pkg::REG_HUM_CHECK_EN:    cfg_reg.hum_check_enable <= cfg_wdata[0];
                dtem_pkg::REG_HUM_LOW_CPCT:
                    cfg_reg.hum_low_cpct <= cfg_wdata[dtem_pkg::HUM_W-1:0];
                dtem_pkg::REG_HUM_HIGH_CPCT:
                    cfg_reg.hum_high_cpct <= cfg_wdata[dtem_pkg::HUM_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// File: sv/dtem_eval.sv
// Per-word evaluation: window compares, run counter, statistics update.
// Combinational; uses dtem_pkg for word, configuration and state types.
module dtem_eval (
    input  dtem_pkg::cfg_t      cfg,
    input  dtem_pkg::state_t    st,
    input  dtem_pkg::in_word_t  word,
    output dtem_pkg::state_t    st_next,
    output dtem_pkg::out_word_t result
);

    logic                             valid;
    logic signed [dtem_pkg::TEMP_W-1:0] t;
    logic                             is_low;
    logic                             is_high;
    logic                             outside;
    logic                             hum_bad;
    logic                             stepped;
    logic [dtem_pkg::RUN_W-1:0]       run_inc;
    logic [dtem_pkg::CNT_W-1:0]       period_ext;

    assign valid = cfg.source_is_probe ? word.probe_valid : word.ambient_valid;
    assign t     = cfg.source_is_probe ? word.probe_temp : word.ambient_cc;

    assign is_low     = t < cfg.temp_low_cc;
    assign is_high    = !is_low && (t > cfg.temp_high_cc);
    assign outside    = is_low || is_high;
    assign hum_bad    = cfg.hum_check_enable && word.hum_valid &&
                        ((word.humidity_raw < cfg.hum_low_cpct) ||
                         (word.humidity_raw > cfg.hum_high_cpct));
    assign stepped    = st.run_length != dtem_pkg::RUN_MAX;
    assign run_inc    = stepped ? st.run_length + 1'b1 : st.run_length;
    assign period_ext = {{(dtem_pkg::CNT_W-16){1'b0}}, cfg.sample_period_s};

    always_comb begin
        st_next = st;
        result  = '0;
        if (valid) begin
            if (is_low) begin
                st_next.low_seconds = st.low_seconds + period_ext;
            end
            if (is_high) begin
                st_next.high_seconds = st.high_seconds + period_ext;
            end
            if (outside) begin
                st_next.run_length = run_inc;
                if (stepped && (run_inc == cfg.debounce_count)) begin
                    st_next.event_count = st.event_count + 1'b1;
                    result.alarm_rise   = 1'b1;
                end
                if (run_inc >= cfg.debounce_count) begin
                    st_next.alarm_latched = 1'b1;
                end
            end else begin
                st_next.run_length = '0;
            end
            if (t < st.min_seen) begin
                st_next.min_seen = t;
            end
            if (t > st.max_seen) begin
                st_next.max_seen = t;
            end
            if (t > dtem_pkg::SAMPLE_FLOOR_CC) begin
                st_next.sample_count = st.sample_count + 1'b1;
            end
            result.exc_low    = is_low;
            result.exc_high   = is_high;
            result.exc_hum    = hum_bad;
            result.alarm_flag = st_next.alarm_latched;
        end
        result.event_total  = st_next.event_count;
        result.seconds_low  = st_next.low_seconds;
        result.seconds_high = st_next.high_seconds;
        result.lowest_cc    = st_next.min_seen;
        result.highest_cc   = st_next.max_seen;
        result.sample_total = st_next.sample_count;
    end

endmodule

// File: sv/debounced_temperature_excursion_monitor.sv
// Top level of the debounced temperature excursion monitor.
// Input word register, monitor state, result register; uses dtem_pkg,
// dtem_cfg_regs and dtem_eval.
//
//   channel   direction   ports                          moves
//   s_        in          s_valid, s_ready, s_word       sensor record word
//   m_        out         m_valid, m_ready, m_word       result word
//   cfg_      in          cfg_wr_en, cfg_addr, cfg_wdata register write
//
// Each word passes the input register, then the result register; one word per cycle sustained while m_ready stays high.
// The state update and result compute sit between the input and result
// registers, and the state register feeds back through that update alone.
// Reset clears both valid flags, resets the state and restores the configuration defaults.
// A stalled result holds the result register and the input register;
// s_ready stays high while the input register is empty or its word can advance.
module debounced_temperature_excursion_monitor (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  dtem_pkg::in_word_t          s_word,
    output logic                        m_valid,
    input  logic                        m_ready,
    output dtem_pkg::out_word_t         m_word,
    input  logic                        cfg_wr_en,
    input  logic [2:0]                  cfg_addr,
    input  logic [dtem_pkg::CFG_W-1:0]  cfg_wdata
);

    dtem_pkg::cfg_t      cfg;
    dtem_pkg::in_word_t  in_word_reg;
    logic                in_valid_reg;
    dtem_pkg::state_t    st_reg;
    dtem_pkg::state_t    st_next;
    dtem_pkg::out_word_t result;
    dtem_pkg::out_word_t out_word_reg;
    logic                out_valid_reg;
    logic                advance;

    dtem_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dtem_eval u_eval (
        .cfg     (cfg),
        .st      (st_reg),
        .word    (in_word_reg),
        .st_next (st_next),
        .result  (result)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_word_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.alarm_latched <= 1'b0;
            st_reg.run_length    <= '0;
            st_reg.event_count   <= '0;
            st_reg.low_seconds   <= '0;
            st_reg.high_seconds  <= '0;
            st_reg.min_seen      <= dtem_pkg::MIN_INIT_CC;
            st_reg.max_seen      <= dtem_pkg::MAX_INIT_CC;
            st_reg.sample_count  <= '0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

endmodule
